// ===== design/e2q_pkg.sv =====
package e2q_pkg;

    // Q.30 working format
    localparam int unsigned QF         = 30;
    localparam int unsigned X_W        = 31;   // half angle magnitude, <= pi/2
    localparam int unsigned TERM_W     = 32;   // series term / x^2 width
    localparam int unsigned NUM_W      = 34;   // term*x2 >> QF
    localparam int unsigned ACC_W      = 36;   // signed partial sums
    localparam int unsigned TRIG_W     = 32;   // signed sin/cos, range +/-2^30
    localparam int unsigned N_TERMS    = 7;
    localparam int unsigned STEP_LAT   = 3;

    localparam logic [31:0] PIQ        = 32'd3373259426;
    localparam logic [31:0] ONEQ       = 32'd1 << QF;

    localparam int unsigned ANGLE_BITS_DEF    = 16;
    localparam int unsigned OUT_FRAC_BITS_DEF = 15;

    // lane front end + series steps + clamp, and the merge pipeline
    localparam int unsigned LANE_LAT  = 2 + N_TERMS * STEP_LAT + 1;
    localparam int unsigned MERGE_LAT = 5;

    typedef struct packed {
        logic [TERM_W-1:0]        ts;
        logic [TERM_W-1:0]        tc;
        logic [TERM_W-1:0]        x2;
        logic signed [ACC_W-1:0]  ss;
        logic signed [ACC_W-1:0]  cs;
        logic                     neg;
    } lane_state_t;

endpackage

// ===== design/e2q_series_step.sv =====
module e2q_series_step #(
    parameter int unsigned K = 1
) (
    input  logic                 clk,
    input  e2q_pkg::lane_state_t in_st,
    output e2q_pkg::lane_state_t out_st
);
    import e2q_pkg::*;

    localparam int unsigned DIV_S = 2 * K * (2 * K + 1);
    localparam int unsigned DIV_C = (2 * K - 1) * (2 * K);
    localparam logic [NUM_W:0] RECIP_S = (NUM_W + 1)'((64'd1 << NUM_W) / 64'(DIV_S));
    localparam logic [NUM_W:0] RECIP_C = (NUM_W + 1)'((64'd1 << NUM_W) / 64'(DIV_C));
    localparam bit SUB = (K % 2) == 1;

    lane_state_t          st1_reg, st2_reg, st1_next;
    logic [2*TERM_W-1:0]  prod_s_reg, prod_c_reg;
    logic [NUM_W-1:0]     num_s_reg, num_c_reg, est_s_reg, est_c_reg;
    logic [NUM_W-1:0]     num_s, num_c;
    logic [2*NUM_W:0]     wide_s, wide_c;
    logic [NUM_W-1:0]     rem_s, rem_c, quo_s, quo_c;
    logic [TERM_W-1:0]    ts_new, tc_new;

    // stage 1: multiply by x^2
    always_ff @(posedge clk)
    begin
        prod_s_reg <= (2*TERM_W)'(in_st.ts) * (2*TERM_W)'(in_st.x2);
        prod_c_reg <= (2*TERM_W)'(in_st.tc) * (2*TERM_W)'(in_st.x2);
        st1_reg    <= in_st;
    end

    // stage 2: reciprocal estimate, low by at most one
    assign num_s  = prod_s_reg[QF +: NUM_W];
    assign num_c  = prod_c_reg[QF +: NUM_W];
    assign wide_s = (2*NUM_W + 1)'(num_s) * (2*NUM_W + 1)'(RECIP_S);
    assign wide_c = (2*NUM_W + 1)'(num_c) * (2*NUM_W + 1)'(RECIP_C);

    always_ff @(posedge clk)
    begin
        num_s_reg <= num_s;
        num_c_reg <= num_c;
        est_s_reg <= wide_s[NUM_W +: NUM_W];
        est_c_reg <= wide_c[NUM_W +: NUM_W];
        st2_reg   <= st1_reg;
    end

    // stage 3: correct quotient, accumulate
    always_comb
    begin
        rem_s  = num_s_reg - NUM_W'(est_s_reg * NUM_W'(DIV_S));
        rem_c  = num_c_reg - NUM_W'(est_c_reg * NUM_W'(DIV_C));
        quo_s  = (rem_s >= NUM_W'(DIV_S)) ? est_s_reg + NUM_W'(1) : est_s_reg;
        quo_c  = (rem_c >= NUM_W'(DIV_C)) ? est_c_reg + NUM_W'(1) : est_c_reg;
        ts_new = TERM_W'(quo_s);
        tc_new = TERM_W'(quo_c);
        st1_next    = st2_reg;
        st1_next.ts = ts_new;
        st1_next.tc = tc_new;
        if (SUB)
        begin
            st1_next.ss = st2_reg.ss - $signed(ACC_W'(ts_new));
            st1_next.cs = st2_reg.cs - $signed(ACC_W'(tc_new));
        end
        else
        begin
            st1_next.ss = st2_reg.ss + $signed(ACC_W'(ts_new));
            st1_next.cs = st2_reg.cs + $signed(ACC_W'(tc_new));
        end
    end

    always_ff @(posedge clk)
    begin
        out_st <= st1_next;
    end

endmodule

// ===== design/e2q_sincos_lane.sv =====
module e2q_sincos_lane #(
    parameter int unsigned ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic [ANGLE_BITS-1:0]               angle,
    output logic signed [e2q_pkg::TRIG_W-1:0]   sin_val,
    output logic signed [e2q_pkg::TRIG_W-1:0]   cos_val
);
    import e2q_pkg::*;

    localparam int unsigned PW = ANGLE_BITS + 32;

    logic                  neg;
    logic [ANGLE_BITS-1:0] mag;
    logic [PW-1:0]         scaled;
    logic [X_W-1:0]        x_reg;
    logic                  neg_reg;
    logic [2*X_W:0]        x_sq;
    lane_state_t           head_reg;
    lane_state_t           chain [N_TERMS+1];
    logic signed [ACC_W-1:0] ss_c, cs_c;

    // |a| * pi / 2^ANGLE_BITS, rounded: half angle in radians
    assign neg    = angle[ANGLE_BITS-1];
    assign mag    = neg ? (~angle + ANGLE_BITS'(1)) : angle;
    assign scaled = PW'(mag) * PW'(PIQ) + (PW'(1) << (ANGLE_BITS - 1));

    always_ff @(posedge clk)
    begin
        x_reg   <= X_W'(scaled >> ANGLE_BITS);
        neg_reg <= neg;
    end

    assign x_sq = (2*X_W + 1)'(x_reg) * (2*X_W + 1)'(x_reg)
                + ((2*X_W + 1)'(1) << (QF - 1));

    always_ff @(posedge clk)
    begin
        head_reg.ts  <= TERM_W'(x_reg);
        head_reg.tc  <= ONEQ;
        head_reg.x2  <= TERM_W'(x_sq >> QF);
        head_reg.ss  <= $signed(ACC_W'(x_reg));
        head_reg.cs  <= $signed(ACC_W'(ONEQ));
        head_reg.neg <= neg_reg;
    end

    assign chain[0] = head_reg;

    for (genvar k = 1; k <= N_TERMS; k++)
    begin : g_term
        e2q_series_step #(.K(k)) u_step (
            .clk    (clk),
            .in_st  (chain[k-1]),
            .out_st (chain[k])
        );
    end

    // clamp to [0, 1.0]; sine takes the angle's sign
    always_comb
    begin
        ss_c = chain[N_TERMS].ss;
        cs_c = chain[N_TERMS].cs;
        if (ss_c < 0)
            ss_c = '0;
        else if (ss_c > $signed(ACC_W'(ONEQ)))
            ss_c = $signed(ACC_W'(ONEQ));
        if (cs_c < 0)
            cs_c = '0;
        else if (cs_c > $signed(ACC_W'(ONEQ)))
            cs_c = $signed(ACC_W'(ONEQ));
    end

    always_ff @(posedge clk)
    begin
        sin_val <= chain[N_TERMS].neg ? -TRIG_W'(ss_c) : TRIG_W'(ss_c);
        cos_val <= TRIG_W'(cs_c);
    end

endmodule

// ===== design/e2q_merge.sv =====
module e2q_merge #(
    parameter int unsigned OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic signed [e2q_pkg::TRIG_W-1:0]   s1,
    input  logic signed [e2q_pkg::TRIG_W-1:0]   c1,
    input  logic signed [e2q_pkg::TRIG_W-1:0]   s2,
    input  logic signed [e2q_pkg::TRIG_W-1:0]   c2,
    input  logic signed [e2q_pkg::TRIG_W-1:0]   s3,
    input  logic signed [e2q_pkg::TRIG_W-1:0]   c3,
    output logic signed [OUT_FRAC_BITS:0]       quat_x,
    output logic signed [OUT_FRAC_BITS:0]       quat_y,
    output logic signed [OUT_FRAC_BITS:0]       quat_z,
    output logic signed [OUT_FRAC_BITS:0]       quat_w
);
    import e2q_pkg::*;

    localparam int unsigned OW  = OUT_FRAC_BITS + 1;
    localparam int unsigned SW  = 33;
    localparam int unsigned SH  = QF - OUT_FRAC_BITS;
    localparam logic [SW-1:0] RND = (SW'(1) << SH) >> 1;
    localparam logic [SW-1:0] LIM = SW'(1) << OUT_FRAC_BITS;

    function automatic logic [X_W-1:0] mag(input logic signed [TRIG_W-1:0] v);
        logic [TRIG_W-1:0] a;
        a = v[TRIG_W-1] ? -v : v;
        return a[X_W-1:0];
    endfunction

    function automatic logic signed [TRIG_W-1:0] rnd_q(input logic [2*X_W-1:0] p,
                                                       input logic neg);
        logic [2*X_W-1:0] r;
        r = (p + ((2*X_W)'(1) << (QF - 1))) >> QF;
        return neg ? -TRIG_W'(r) : TRIG_W'(r);
    endfunction

    function automatic logic [OW-1:0] to_out(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        logic          n;
        n = v[SW-1];
        m = n ? -v : v;
        m = (m + RND) >> SH;
        if (n)
        begin
            if (m > LIM)
                m = LIM;
        end
        else if (m > LIM - SW'(1))
        begin
            m = LIM - SW'(1);
        end
        m = n ? -m : m;
        return m[OW-1:0];
    endfunction

    // M1: inner magnitude products
    logic [2*X_W-1:0]        p_c2s3_reg, p_c2c3_reg, p_s2s3_reg, p_s2c3_reg;
    logic                    n_c2s3_reg, n_c2c3_reg, n_s2s3_reg, n_s2c3_reg;
    logic signed [TRIG_W-1:0] s1_d1_reg, c1_d1_reg, s1_d2_reg, c1_d2_reg;

    always_ff @(posedge clk)
    begin
        p_c2s3_reg <= (2*X_W)'(mag(c2)) * (2*X_W)'(mag(s3));
        p_c2c3_reg <= (2*X_W)'(mag(c2)) * (2*X_W)'(mag(c3));
        p_s2s3_reg <= (2*X_W)'(mag(s2)) * (2*X_W)'(mag(s3));
        p_s2c3_reg <= (2*X_W)'(mag(s2)) * (2*X_W)'(mag(c3));
        n_c2s3_reg <= c2[TRIG_W-1] ^ s3[TRIG_W-1];
        n_c2c3_reg <= c2[TRIG_W-1] ^ c3[TRIG_W-1];
        n_s2s3_reg <= s2[TRIG_W-1] ^ s3[TRIG_W-1];
        n_s2c3_reg <= s2[TRIG_W-1] ^ c3[TRIG_W-1];
        s1_d1_reg  <= s1;
        c1_d1_reg  <= c1;
    end

    // M2: round inner products
    logic signed [TRIG_W-1:0] c2s3_reg, c2c3_reg, s2s3_reg, s2c3_reg;

    always_ff @(posedge clk)
    begin
        c2s3_reg  <= rnd_q(p_c2s3_reg, n_c2s3_reg);
        c2c3_reg  <= rnd_q(p_c2c3_reg, n_c2c3_reg);
        s2s3_reg  <= rnd_q(p_s2s3_reg, n_s2s3_reg);
        s2c3_reg  <= rnd_q(p_s2c3_reg, n_s2c3_reg);
        s1_d2_reg <= s1_d1_reg;
        c1_d2_reg <= c1_d1_reg;
    end

    // M3: outer products, order c1*c2s3, s1*s2c3, c1*s2c3, s1*c2s3,
    //     s1*c2c3, c1*s2s3, c1*c2c3, s1*s2s3
    logic signed [TRIG_W-1:0] opa [8];
    logic signed [TRIG_W-1:0] opb [8];
    logic [2*X_W-1:0]         pp_reg [8];
    logic                     pn_reg [8];

    always_comb
    begin
        opa[0] = c1_d2_reg; opb[0] = c2s3_reg;
        opa[1] = s1_d2_reg; opb[1] = s2c3_reg;
        opa[2] = c1_d2_reg; opb[2] = s2c3_reg;
        opa[3] = s1_d2_reg; opb[3] = c2s3_reg;
        opa[4] = s1_d2_reg; opb[4] = c2c3_reg;
        opa[5] = c1_d2_reg; opb[5] = s2s3_reg;
        opa[6] = c1_d2_reg; opb[6] = c2c3_reg;
        opa[7] = s1_d2_reg; opb[7] = s2s3_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            pp_reg[i] <= (2*X_W)'(mag(opa[i])) * (2*X_W)'(mag(opb[i]));
            pn_reg[i] <= opa[i][TRIG_W-1] ^ opb[i][TRIG_W-1];
        end
    end

    // M4: round and combine
    logic signed [TRIG_W-1:0] r [8];
    logic signed [SW-1:0]     sx_reg, sy_reg, sz_reg, sw_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            r[i] = rnd_q(pp_reg[i], pn_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= SW'(r[0]) + SW'(r[1]);
        sz_reg <= SW'(r[2]) - SW'(r[3]);
        sy_reg <= SW'(r[4]) - SW'(r[5]);
        sw_reg <= SW'(r[6]) + SW'(r[7]);
    end

    // M5: round to output format, saturate
    always_ff @(posedge clk)
    begin
        quat_x <= to_out(sx_reg);
        quat_y <= to_out(sy_reg);
        quat_z <= to_out(sz_reg);
        quat_w <= to_out(sw_reg);
    end

endmodule

// ===== design/euler_to_quaternion_unit.sv =====
// Euler angles to rotation quaternion.
// Command channel: yaw_angle, pitch_angle and roll_angle are two's complement
// binary angles (2^ANGLE_BITS = one turn). A transaction is taken at each
// rising edge with start high and busy low; busy never rises, so a new
// transaction may be issued every cycle.
// Result channel: quat_x/y/z/w, signed Q1.OUT_FRAC_BITS, appear for exactly
// one cycle with done high. Results come out in issue order; the receiver
// cannot stall them, so it must take each one as it appears.
// The angles pass through the sine/cosine lanes and then the merge. Throughput:
// one transaction per cycle, set by the fully pipelined lanes and merge.
// Reset clears only the done pipeline; data registers are not reset. Results in
// flight at reset are lost, and none is invented once rst_n is released.
module euler_to_quaternion_unit #(
    parameter int unsigned ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
    parameter int unsigned OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ANGLE_BITS-1:0] yaw_angle,
    input  logic signed [ANGLE_BITS-1:0] pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] roll_angle,
    output logic                         done,
    output logic signed [OUT_FRAC_BITS:0] quat_x,
    output logic signed [OUT_FRAC_BITS:0] quat_y,
    output logic signed [OUT_FRAC_BITS:0] quat_z,
    output logic signed [OUT_FRAC_BITS:0] quat_w
);
    import e2q_pkg::*;

    localparam int unsigned LAT = LANE_LAT + MERGE_LAT;

    logic [LAT-1:0]           vld_reg, vld_next;
    logic signed [TRIG_W-1:0] s1, c1, s2, c2, s3, c3;

    // fully pipelined, so never stalls the issuer
    assign busy = 1'b0;

    // transaction tracking through the fixed-latency pipe
    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign done = vld_reg[LAT-1];

    // lanes: yaw gives c1/s1, roll gives c2/s2, pitch gives c3/s3
    e2q_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_yaw (
        .clk     (clk),
        .angle   (yaw_angle),
        .sin_val (s1),
        .cos_val (c1)
    );

    e2q_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_roll (
        .clk     (clk),
        .angle   (roll_angle),
        .sin_val (s2),
        .cos_val (c2)
    );

    e2q_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_pitch (
        .clk     (clk),
        .angle   (pitch_angle),
        .sin_val (s3),
        .cos_val (c3)
    );

    // combine half-angle terms into x, y, z, w
    e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
        .clk    (clk),
        .s1     (s1),
        .c1     (c1),
        .s2     (s2),
        .c2     (c2),
        .s3     (s3),
        .c3     (c3),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .quat_w (quat_w)
    );

endmodule
